// ===== rtl/dd_odom_pkg.sv =====
// dd_odom_pkg: shared types, constants and small arithmetic helpers for the
// differential drive odometry block
// no dependencies
package dd_odom_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HINC,
        ST_KFAC,
        ST_LIN,
        ST_ANG,
        ST_ANGD,
        ST_SC_X,
        ST_SC_X2,
        ST_SC_X2R,
        ST_SC_N,
        ST_SC_Q,
        ST_SC_C,
        ST_SC_R,
        ST_SC_END,
        ST_PX_LO,
        ST_PX_HI,
        ST_PX_ADD,
        ST_PY_LO,
        ST_PY_HI,
        ST_PY_ADD,
        ST_V_LO,
        ST_V_HI,
        ST_V_SET,
        ST_V_DIV,
        ST_V_END,
        ST_DONE
    } state_t;

    // configuration register indexes
    localparam logic [1:0] CFG_METERS_PER_TICK = 2'd0;
    localparam logic [1:0] CFG_INV_WHEEL_BASE  = 2'd1;
    localparam logic [1:0] CFG_ANGLE_STEP      = 2'd2;

    localparam logic [23:0] MPT_RESET   = 24'd819218;
    localparam logic [23:0] IWB_RESET   = 24'd163840;
    localparam logic [23:0] ASTEP_RESET = 24'd162978;

    localparam logic [29:0] PI4_Q30      = 30'd843314857;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;
    localparam logic [30:0] QUARTER_TURN = 31'h4000_0000;
    localparam logic [29:0] OCTANT       = 30'h2000_0000;
    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

    localparam logic [2:0] TERM_FIRST = 3'd1;
    localparam logic [2:0] TERM_LAST  = 3'd6;
    localparam logic [5:0] DIV_LAST   = 6'd32;

    localparam logic [32:0] MAG_POS_MAX = 33'h0_7FFF_FFFF;
    localparam logic [32:0] MAG_NEG_MAX = 33'h0_8000_0000;
    localparam logic [31:0] VEL_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_MIN     = 32'h8000_0000;

    // series term divisors: sine k -> 2k(2k+1), cosine k -> (2k-1)2k
    function automatic logic [7:0] term_divisor(input logic [2:0] k, input logic cos_sel);
        logic [7:0] d;
        begin
            unique case ({k, cos_sel})
                4'b001_0: d = 8'd6;
                4'b010_0: d = 8'd20;
                4'b011_0: d = 8'd42;
                4'b100_0: d = 8'd72;
                4'b101_0: d = 8'd110;
                4'b110_0: d = 8'd156;
                4'b001_1: d = 8'd2;
                4'b010_1: d = 8'd12;
                4'b011_1: d = 8'd30;
                4'b100_1: d = 8'd56;
                4'b101_1: d = 8'd90;
                4'b110_1: d = 8'd132;
                default:  d = 8'd1;
            endcase
            return d;
        end
    endfunction

    // floor(2^32 / divisor); quotient estimate is low by at most one
    function automatic logic [31:0] term_recip(input logic [2:0] k, input logic cos_sel);
        logic [31:0] m;
        begin
            unique case ({k, cos_sel})
                4'b001_0: m = 32'd715827882;
                4'b010_0: m = 32'd214748364;
                4'b011_0: m = 32'd102261126;
                4'b100_0: m = 32'd59652323;
                4'b101_0: m = 32'd39045157;
                4'b110_0: m = 32'd27531841;
                4'b001_1: m = 32'd2147483648;
                4'b010_1: m = 32'd357913941;
                4'b011_1: m = 32'd143165576;
                4'b100_1: m = 32'd76695844;
                4'b101_1: m = 32'd47721858;
                4'b110_1: m = 32'd32537631;
                default:  m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

    // magnitude of a q1.30 value rounded half away from zero to q1.22
    function automatic logic [22:0] trig_q22_mag(input logic [31:0] t);
        logic [31:0] a;
        logic [31:0] r;
        begin
            a = t[31] ? (~t + 32'd1) : t;
            r = a + 32'd128;
            return r[30:8];
        end
    endfunction

    // q1.30 value rounded half away from zero to q2.14
    function automatic logic [15:0] quat_q14(input logic [31:0] t);
        logic [31:0] a;
        logic [31:0] r;
        begin
            a = t[31] ? (~t + 32'd1) : t;
            r = a + 32'h0000_8000;
            return t[31] ? (16'd0 - r[31:16]) : r[31:16];
        end
    endfunction

endpackage

// ===== rtl/diff_drive_odometry.sv =====
// diff_drive_odometry: dead reckoning pose and velocity from wheel counters
// depends on dd_odom_pkg
// one item in flight: in_stall holds the input until the result is loaded, which
//   also waits while a previous result is held by out_stall
// the run time is set by one shared 33x32 multiplier (88 passes) and a one bit
// per cycle divider that runs 33 steps for each of the two velocities; the
// division is skipped when elapsed_us is 0 or a velocity saturates early
// reset: pose and counter history cleared, registers at defaults, no result pending
module diff_drive_odometry (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        left_count,
    input  logic [31:0]        right_count,
    input  logic [23:0]        elapsed_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] x_position,
    output logic signed [31:0] y_position,
    output logic [31:0]        heading_angle,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic signed [31:0] linear_velocity,
    output logic signed [31:0] yaw_rate
);

    // ---------------------------------------------------------------
    // control and architectural state (reset)
    // ---------------------------------------------------------------
    dd_odom_pkg::state_t state_reg, state_next;
    logic [23:0] mpt_reg, mpt_next;          // meters per tick
    logic [23:0] iwb_reg, iwb_next;          // inverse wheel base
    logic [23:0] astep_reg, astep_next;      // angle per tick difference
    logic [31:0] last_left_reg, last_left_next;
    logic [31:0] last_right_reg, last_right_next;
    logic [31:0] x_accum_reg, x_accum_next;
    logic [31:0] y_accum_reg, y_accum_next;
    logic [31:0] heading_reg, heading_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  k_reg, k_next;              // series term number
    logic        cos_sel_reg, cos_sel_next;  // which series term is in work
    logic        pass_reg, pass_next;        // first trig pass: full heading angle
    logic        vel_sel_reg, vel_sel_next;  // 0 linear, 1 angular
    logic [5:0]  cnt_reg, cnt_next;          // divider step

    // ---------------------------------------------------------------
    // datapath registers (no reset)
    // ---------------------------------------------------------------
    logic [64:0] prod_reg;                   // shared multiplier output
    logic [32:0] msum_reg, msum_next;
    logic [31:0] mdiff_reg, mdiff_next;
    logic        sum_neg_reg, sum_neg_next;
    logic        diff_neg_reg, diff_neg_next;
    logic [31:0] diff_lo_reg, diff_lo_next;
    logic [23:0] dt_reg, dt_next;
    logic [31:0] k32_reg, k32_next;
    logic [56:0] lin_m_reg, lin_m_next;
    logic [63:0] ang_m_reg, ang_m_next;
    logic [39:0] travel_reg, travel_next;
    logic [31:0] sc_angle_reg, sc_angle_next;
    logic        sc_swap_reg, sc_swap_next;
    logic [29:0] x2_reg, x2_next;
    logic [30:0] ts_reg, ts_next;
    logic [30:0] tc_reg, tc_next;
    logic signed [31:0] sv_reg, sv_next;
    logic signed [31:0] cv_reg, cv_next;
    logic [29:0] n_reg, n_next;
    logic [29:0] q0_reg, q0_next;
    logic signed [31:0] st_reg, st_next;
    logic signed [31:0] ct_reg, ct_next;
    logic signed [31:0] sh_reg, sh_next;
    logic signed [31:0] ch_reg, ch_next;
    logic [63:0] wlo_reg, wlo_next;          // low partial product
    logic [40:0] rem_reg, rem_next;
    logic [32:0] pq_reg, pq_next;            // dividend bits in, quotient bits out
    logic [40:0] den_reg, den_next;
    logic        vzero_reg, vzero_next;
    logic        vovf_reg, vovf_next;
    logic [31:0] lin_vel_reg, lin_vel_next;
    logic [31:0] ang_vel_reg, ang_vel_next;

    // result register
    logic [31:0] x_out_reg, x_out_next;
    logic [31:0] y_out_reg, y_out_next;
    logic [31:0] hd_out_reg, hd_out_next;
    logic [15:0] qz_out_reg, qz_out_next;
    logic [15:0] qw_out_reg, qw_out_next;
    logic [31:0] lv_out_reg, lv_out_next;
    logic [31:0] av_out_reg, av_out_next;

    // shared multiplier operands
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    // helpers
    logic [22:0] ct8_mag;
    logic [22:0] st8_mag;
    logic [63:0] vel_m;
    logic [7:0]  term_d;
    logic [31:0] term_m;

    assign ct8_mag = dd_odom_pkg::trig_q22_mag(ct_reg);
    assign st8_mag = dd_odom_pkg::trig_q22_mag(st_reg);
    assign vel_m   = vel_sel_reg ? ang_m_reg : {7'd0, lin_m_reg};
    assign term_d  = dd_odom_pkg::term_divisor(k_reg, cos_sel_reg);
    assign term_m  = dd_odom_pkg::term_recip(k_reg, cos_sel_reg);

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    assign in_stall         = (state_reg != dd_odom_pkg::ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign x_position       = x_out_reg;
    assign y_position       = y_out_reg;
    assign heading_angle    = hd_out_reg;
    assign quat_z           = qz_out_reg;
    assign quat_w           = qw_out_reg;
    assign linear_velocity  = lv_out_reg;
    assign yaw_rate         = av_out_reg;

    // ---------------------------------------------------------------
    // sequencer: next state, operand select and datapath updates
    // ---------------------------------------------------------------
    always_comb
    begin
        logic [31:0] dl;
        logic [31:0] dr;
        logic [32:0] sum;
        logic [32:0] diff;
        logic [32:0] diff_abs;
        logic [57:0] lin_round;
        logic [29:0] f;
        logic        swap;
        logic [30:0] r_fold;
        logic [31:0] rmd;
        logic [29:0] q;
        logic signed [31:0] qs;
        logic signed [31:0] ps;
        logic signed [31:0] pc;
        logic signed [31:0] s_res;
        logic signed [31:0] c_res;
        logic [63:0] full;
        logic [63:0] rnd;
        logic [31:0] step32;
        logic [31:0] delta;
        logic [83:0] big_p;
        logic [40:0] den;
        logic [42:0] trial;
        logic        qbit;
        logic        vneg;
        logic [31:0] vres;

        dl        = 32'd0;
        dr        = 32'd0;
        sum       = 33'd0;
        diff      = 33'd0;
        diff_abs  = 33'd0;
        lin_round = 58'd0;
        f         = 30'd0;
        swap      = 1'b0;
        r_fold    = 31'd0;
        rmd       = 32'd0;
        q         = 30'd0;
        qs        = 32'sd0;
        ps        = 32'sd0;
        pc        = 32'sd0;
        s_res     = 32'sd0;
        c_res     = 32'sd0;
        full      = 64'd0;
        rnd       = 64'd0;
        step32    = 32'd0;
        delta     = 32'd0;
        big_p     = 84'd0;
        den       = 41'd0;
        trial     = 43'd0;
        qbit      = 1'b0;
        vneg      = 1'b0;
        vres      = 32'd0;

        state_next      = state_reg;
        mpt_next        = mpt_reg;
        iwb_next        = iwb_reg;
        astep_next      = astep_reg;
        last_left_next  = last_left_reg;
        last_right_next = last_right_reg;
        x_accum_next    = x_accum_reg;
        y_accum_next    = y_accum_reg;
        heading_next    = heading_reg;
        out_valid_next  = out_valid_reg;
        k_next          = k_reg;
        cos_sel_next    = cos_sel_reg;
        pass_next       = pass_reg;
        vel_sel_next    = vel_sel_reg;
        cnt_next        = cnt_reg;

        msum_next     = msum_reg;
        mdiff_next    = mdiff_reg;
        sum_neg_next  = sum_neg_reg;
        diff_neg_next = diff_neg_reg;
        diff_lo_next  = diff_lo_reg;
        dt_next       = dt_reg;
        k32_next      = k32_reg;
        lin_m_next    = lin_m_reg;
        ang_m_next    = ang_m_reg;
        travel_next   = travel_reg;
        sc_angle_next = sc_angle_reg;
        sc_swap_next  = sc_swap_reg;
        x2_next       = x2_reg;
        ts_next       = ts_reg;
        tc_next       = tc_reg;
        sv_next       = sv_reg;
        cv_next       = cv_reg;
        n_next        = n_reg;
        q0_next       = q0_reg;
        st_next       = st_reg;
        ct_next       = ct_reg;
        sh_next       = sh_reg;
        ch_next       = ch_reg;
        wlo_next      = wlo_reg;
        rem_next      = rem_reg;
        pq_next       = pq_reg;
        den_next      = den_reg;
        vzero_next    = vzero_reg;
        vovf_next     = vovf_reg;
        lin_vel_next  = lin_vel_reg;
        ang_vel_next  = ang_vel_reg;

        x_out_next  = x_out_reg;
        y_out_next  = y_out_reg;
        hd_out_next = hd_out_reg;
        qz_out_next = qz_out_reg;
        qw_out_next = qw_out_reg;
        lv_out_next = lv_out_reg;
        av_out_next = av_out_reg;

        mul_a = 33'd0;
        mul_b = 32'd0;

        // result register drains independently of the sequencer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // the user must make register writes only while idle; the block does not enforce it
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                dd_odom_pkg::CFG_METERS_PER_TICK: mpt_next   = cfg_data;
                dd_odom_pkg::CFG_INV_WHEEL_BASE:  iwb_next   = cfg_data;
                dd_odom_pkg::CFG_ANGLE_STEP:      astep_next = cfg_data;
                default:                          ;
            endcase
        end

        unique case (state_reg)
            dd_odom_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    // tick deltas modulo 2^32, read as signed
                    dl   = left_count - last_left_reg;
                    dr   = right_count - last_right_reg;
                    sum  = {dl[31], dl} + {dr[31], dr};
                    diff = {dr[31], dr} - {dl[31], dl};
                    diff_abs = diff[32] ? (33'd0 - diff) : diff;
                    msum_next     = sum[32] ? (33'd0 - sum) : sum;
                    mdiff_next    = diff_abs[31:0];
                    sum_neg_next  = sum[32];
                    diff_neg_next = diff[32];
                    diff_lo_next  = diff[31:0];
                    dt_next       = elapsed_us;
                    last_left_next  = left_count;
                    last_right_next = right_count;
                    state_next = dd_odom_pkg::ST_HINC;
                end
            end

            dd_odom_pkg::ST_HINC:
            begin
                // heading increment, only the low word matters
                mul_a = {1'b0, diff_lo_reg};
                mul_b = {8'd0, astep_reg};
                state_next = dd_odom_pkg::ST_KFAC;
            end

            dd_odom_pkg::ST_KFAC:
            begin
                heading_next = heading_reg + prod_reg[31:0];
                mul_a = {9'd0, mpt_reg};
                mul_b = {8'd0, iwb_reg};
                state_next = dd_odom_pkg::ST_LIN;
            end

            dd_odom_pkg::ST_LIN:
            begin
                k32_next = prod_reg[47:16];
                mul_a = msum_reg;
                mul_b = {8'd0, mpt_reg};
                state_next = dd_odom_pkg::ST_ANG;
            end

            dd_odom_pkg::ST_ANG:
            begin
                lin_m_next  = prod_reg[56:0];
                lin_round   = {1'b0, prod_reg[56:0]} + 58'h1_0000;
                travel_next = lin_round[56:17];
                mul_a = {1'b0, mdiff_reg};
                mul_b = k32_reg;
                state_next = dd_odom_pkg::ST_ANGD;
            end

            dd_odom_pkg::ST_ANGD:
            begin
                ang_m_next    = prod_reg[63:0];
                // position uses twice the heading angle as a full-turn angle
                sc_angle_next = {heading_reg[30:0], 1'b0};
                pass_next     = 1'b0;
                state_next    = dd_odom_pkg::ST_SC_X;
            end

            dd_odom_pkg::ST_SC_X:
            begin
                // fold into the first octant
                f      = sc_angle_reg[29:0];
                swap   = (f > dd_odom_pkg::OCTANT);
                r_fold = dd_odom_pkg::QUARTER_TURN - {1'b0, f};
                sc_swap_next = swap;
                mul_a = {3'd0, (swap ? r_fold[29:0] : f)};
                mul_b = {2'd0, dd_odom_pkg::PI4_Q30};
                state_next = dd_odom_pkg::ST_SC_X2;
            end

            dd_odom_pkg::ST_SC_X2:
            begin
                ts_next      = {1'b0, prod_reg[58:29]};
                sv_next      = $signed({2'b00, prod_reg[58:29]});
                tc_next      = dd_odom_pkg::Q30_ONE;
                cv_next      = $signed({1'b0, dd_odom_pkg::Q30_ONE});
                k_next       = dd_odom_pkg::TERM_FIRST;
                cos_sel_next = 1'b0;
                mul_a = {3'd0, prod_reg[58:29]};
                mul_b = {2'd0, prod_reg[58:29]};
                state_next = dd_odom_pkg::ST_SC_X2R;
            end

            dd_odom_pkg::ST_SC_X2R:
            begin
                x2_next    = prod_reg[59:30];
                state_next = dd_odom_pkg::ST_SC_N;
            end

            dd_odom_pkg::ST_SC_N:
            begin
                mul_a = {2'd0, (cos_sel_reg ? tc_reg : ts_reg)};
                mul_b = {2'd0, x2_reg};
                state_next = dd_odom_pkg::ST_SC_Q;
            end

            dd_odom_pkg::ST_SC_Q:
            begin
                // quotient estimate by reciprocal
                n_next = prod_reg[59:30];
                mul_a  = {3'd0, prod_reg[59:30]};
                mul_b  = term_m;
                state_next = dd_odom_pkg::ST_SC_C;
            end

            dd_odom_pkg::ST_SC_C:
            begin
                q0_next = prod_reg[61:32];
                mul_a   = {3'd0, prod_reg[61:32]};
                mul_b   = {24'd0, term_d};
                state_next = dd_odom_pkg::ST_SC_R;
            end

            dd_odom_pkg::ST_SC_R:
            begin
                // one correction step, remainder below twice the divisor
                rmd = {2'b00, n_reg} - prod_reg[31:0];
                q   = q0_reg + ((rmd >= {24'd0, term_d}) ? 30'd1 : 30'd0);
                qs  = $signed({2'b00, q});
                if (cos_sel_reg)
                begin
                    tc_next = {1'b0, q};
                    cv_next = k_reg[0] ? (cv_reg - qs) : (cv_reg + qs);
                end
                else
                begin
                    ts_next = {1'b0, q};
                    sv_next = k_reg[0] ? (sv_reg - qs) : (sv_reg + qs);
                end
                if (!cos_sel_reg)
                begin
                    cos_sel_next = 1'b1;
                    state_next   = dd_odom_pkg::ST_SC_N;
                end
                else
                begin
                    cos_sel_next = 1'b0;
                    if (k_reg == dd_odom_pkg::TERM_LAST)
                    begin
                        state_next = dd_odom_pkg::ST_SC_END;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = dd_odom_pkg::ST_SC_N;
                    end
                end
            end

            dd_odom_pkg::ST_SC_END:
            begin
                ps = sc_swap_reg ? cv_reg : sv_reg;
                pc = sc_swap_reg ? sv_reg : cv_reg;
                unique case (sc_angle_reg[31:30])
                    2'd0:
                    begin
                        s_res = ps;
                        c_res = pc;
                    end
                    2'd1:
                    begin
                        s_res = pc;
                        c_res = -ps;
                    end
                    2'd2:
                    begin
                        s_res = -ps;
                        c_res = -pc;
                    end
                    default:
                    begin
                        s_res = -pc;
                        c_res = ps;
                    end
                endcase
                if (!pass_reg)
                begin
                    st_next    = s_res;
                    ct_next    = c_res;
                    state_next = dd_odom_pkg::ST_PX_LO;
                end
                else
                begin
                    sh_next      = s_res;
                    ch_next      = c_res;
                    vel_sel_next = 1'b0;
                    state_next   = dd_odom_pkg::ST_V_LO;
                end
            end

            dd_odom_pkg::ST_PX_LO:
            begin
                mul_a = {1'b0, travel_reg[31:0]};
                mul_b = {9'd0, ct8_mag};
                state_next = dd_odom_pkg::ST_PX_HI;
            end

            dd_odom_pkg::ST_PX_HI:
            begin
                wlo_next = prod_reg[63:0];
                mul_a = {25'd0, travel_reg[39:32]};
                mul_b = {9'd0, ct8_mag};
                state_next = dd_odom_pkg::ST_PX_ADD;
            end

            dd_odom_pkg::ST_PX_ADD:
            begin
                full   = wlo_reg + {prod_reg[31:0], 32'd0};
                rnd    = full + 64'h20_0000;
                step32 = rnd[53:22];
                delta  = (sum_neg_reg ^ ct_reg[31]) ? (32'd0 - step32) : step32;
                x_accum_next = x_accum_reg + delta;
                state_next   = dd_odom_pkg::ST_PY_LO;
            end

            dd_odom_pkg::ST_PY_LO:
            begin
                mul_a = {1'b0, travel_reg[31:0]};
                mul_b = {9'd0, st8_mag};
                state_next = dd_odom_pkg::ST_PY_HI;
            end

            dd_odom_pkg::ST_PY_HI:
            begin
                wlo_next = prod_reg[63:0];
                mul_a = {25'd0, travel_reg[39:32]};
                mul_b = {9'd0, st8_mag};
                state_next = dd_odom_pkg::ST_PY_ADD;
            end

            dd_odom_pkg::ST_PY_ADD:
            begin
                full   = wlo_reg + {prod_reg[31:0], 32'd0};
                rnd    = full + 64'h20_0000;
                step32 = rnd[53:22];
                delta  = (sum_neg_reg ^ st_reg[31]) ? (32'd0 - step32) : step32;
                y_accum_next  = y_accum_reg + delta;
                // quaternion terms use the half-heading angle
                sc_angle_next = heading_reg;
                pass_next     = 1'b1;
                state_next    = dd_odom_pkg::ST_SC_X;
            end

            dd_odom_pkg::ST_V_LO:
            begin
                mul_a = {1'b0, vel_m[31:0]};
                mul_b = dd_odom_pkg::USEC_PER_SEC;
                state_next = dd_odom_pkg::ST_V_HI;
            end

            dd_odom_pkg::ST_V_HI:
            begin
                wlo_next = prod_reg[63:0];
                mul_a = {1'b0, vel_m[63:32]};
                mul_b = dd_odom_pkg::USEC_PER_SEC;
                state_next = dd_odom_pkg::ST_V_SET;
            end

            dd_odom_pkg::ST_V_SET:
            begin
                // dividend is magnitude * 1e6, divisor folds in the final shift
                big_p = 84'(wlo_reg) + {prod_reg[51:0], 32'd0};
                den   = vel_sel_reg ? {1'b0, dt_reg, 16'd0} : {dt_reg, 17'd0};
                den_next   = den;
                vzero_next = (dt_reg == 24'd0);
                vovf_next  = (big_p[83:33] >= {10'd0, den});
                rem_next   = big_p[73:33];
                pq_next    = big_p[32:0];
                cnt_next   = 6'd0;
                if ((dt_reg == 24'd0) || (big_p[83:33] >= {10'd0, den}))
                begin
                    state_next = dd_odom_pkg::ST_V_END;
                end
                else
                begin
                    state_next = dd_odom_pkg::ST_V_DIV;
                end
            end

            dd_odom_pkg::ST_V_DIV:
            begin
                trial = {1'b0, rem_reg, pq_reg[32]} - {2'b00, den_reg};
                qbit  = !trial[42];
                rem_next = qbit ? trial[40:0] : {rem_reg[39:0], pq_reg[32]};
                pq_next  = {pq_reg[31:0], qbit};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == dd_odom_pkg::DIV_LAST)
                begin
                    state_next = dd_odom_pkg::ST_V_END;
                end
            end

            dd_odom_pkg::ST_V_END:
            begin
                vneg = vel_sel_reg ? diff_neg_reg : sum_neg_reg;
                priority if (vzero_reg)
                begin
                    vres = 32'd0;
                end
                else if (vneg)
                begin
                    vres = (vovf_reg || (pq_reg > dd_odom_pkg::MAG_NEG_MAX)) ?
                           dd_odom_pkg::VEL_MIN : (32'd0 - pq_reg[31:0]);
                end
                else
                begin
                    vres = (vovf_reg || (pq_reg > dd_odom_pkg::MAG_POS_MAX)) ?
                           dd_odom_pkg::VEL_MAX : pq_reg[31:0];
                end
                if (vel_sel_reg)
                begin
                    ang_vel_next = vres;
                    state_next   = dd_odom_pkg::ST_DONE;
                end
                else
                begin
                    lin_vel_next = vres;
                    vel_sel_next = 1'b1;
                    state_next   = dd_odom_pkg::ST_V_LO;
                end
            end

            dd_odom_pkg::ST_DONE:
            begin
                // load when the result register is empty or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    x_out_next     = x_accum_reg;
                    y_out_next     = y_accum_reg;
                    hd_out_next    = heading_reg;
                    qz_out_next    = dd_odom_pkg::quat_q14(sh_reg);
                    qw_out_next    = dd_odom_pkg::quat_q14(ch_reg);
                    lv_out_next    = lin_vel_reg;
                    av_out_next    = ang_vel_reg;
                    out_valid_next = 1'b1;
                    state_next     = dd_odom_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dd_odom_pkg::ST_IDLE;
            end
        endcase
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dd_odom_pkg::ST_IDLE;
            mpt_reg        <= dd_odom_pkg::MPT_RESET;
            iwb_reg        <= dd_odom_pkg::IWB_RESET;
            astep_reg      <= dd_odom_pkg::ASTEP_RESET;
            last_left_reg  <= 32'd0;
            last_right_reg <= 32'd0;
            x_accum_reg    <= 32'd0;
            y_accum_reg    <= 32'd0;
            heading_reg    <= 32'd0;
            out_valid_reg  <= 1'b0;
            k_reg          <= dd_odom_pkg::TERM_FIRST;
            cos_sel_reg    <= 1'b0;
            pass_reg       <= 1'b0;
            vel_sel_reg    <= 1'b0;
            cnt_reg        <= 6'd0;
        end
        else
        begin
            state_reg      <= state_next;
            mpt_reg        <= mpt_next;
            iwb_reg        <= iwb_next;
            astep_reg      <= astep_next;
            last_left_reg  <= last_left_next;
            last_right_reg <= last_right_next;
            x_accum_reg    <= x_accum_next;
            y_accum_reg    <= y_accum_next;
            heading_reg    <= heading_next;
            out_valid_reg  <= out_valid_next;
            k_reg          <= k_next;
            cos_sel_reg    <= cos_sel_next;
            pass_reg       <= pass_next;
            vel_sel_reg    <= vel_sel_next;
            cnt_reg        <= cnt_next;
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_p;
        msum_reg     <= msum_next;
        mdiff_reg    <= mdiff_next;
        sum_neg_reg  <= sum_neg_next;
        diff_neg_reg <= diff_neg_next;
        diff_lo_reg  <= diff_lo_next;
        dt_reg       <= dt_next;
        k32_reg      <= k32_next;
        lin_m_reg    <= lin_m_next;
        ang_m_reg    <= ang_m_next;
        travel_reg   <= travel_next;
        sc_angle_reg <= sc_angle_next;
        sc_swap_reg  <= sc_swap_next;
        x2_reg       <= x2_next;
        ts_reg       <= ts_next;
        tc_reg       <= tc_next;
        sv_reg       <= sv_next;
        cv_reg       <= cv_next;
        n_reg        <= n_next;
        q0_reg       <= q0_next;
        st_reg       <= st_next;
        ct_reg       <= ct_next;
        sh_reg       <= sh_next;
        ch_reg       <= ch_next;
        wlo_reg      <= wlo_next;
        rem_reg      <= rem_next;
        pq_reg       <= pq_next;
        den_reg      <= den_next;
        vzero_reg    <= vzero_next;
        vovf_reg     <= vovf_next;
        lin_vel_reg  <= lin_vel_next;
        ang_vel_reg  <= ang_vel_next;
        x_out_reg    <= x_out_next;
        y_out_reg    <= y_out_next;
        hd_out_reg   <= hd_out_next;
        qz_out_reg   <= qz_out_next;
        qw_out_reg   <= qw_out_next;
        lv_out_reg   <= lv_out_next;
        av_out_reg   <= av_out_next;
    end

endmodule
